/* src/checksummed_frame_receiver_macros.svh */
// Assertion macros for the port-level checker of the checksummed frame receiver.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUMMED_FRAME_RECEIVER_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while reset is asserted.
`define CFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for an implication written as antecedent and consequent.
`define CFR_ASSERT_IMPL(label, ante, cons, msg) \
    `CFR_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* src/cfr_pkg.sv */
// Package for the checksummed frame receiver: frame constants, parser phases,
// command type and queue status. Used by every module of the block.
`default_nettype none

package cfr_pkg;

    localparam logic [7:0] HDR1          = 8'hAA;
    localparam logic [7:0] HDR2          = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT    = 8'hF1;
    localparam logic [7:0] ACK_TAG       = 8'hEF;
    localparam logic [7:0] ACK_LEN       = 8'h02;
    localparam logic [7:0] FUNC_ACK_LO   = 8'h10;
    localparam logic [7:0] FUNC_ACK_HI   = 8'h15;
    localparam logic [7:0] FUNC_REQUEST  = 8'h02;
    localparam logic [7:0] SUB_PID       = 8'h01;
    localparam logic [7:0] SUB_VERSION   = 8'hA0;
    localparam logic [7:0] LIMIT_RESET   = 8'd50;

    // Sum of the four fixed leading bytes of an acknowledgement.
    localparam logic [7:0] ACK_PREFIX_SUM = 8'(HDR1 + HDR1 + ACK_TAG + ACK_LEN);
    localparam logic [2:0] ACK_LAST_STEP  = 3'd6;

    localparam int CMD_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_FUNC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CSUM    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CMD_ACK     = 2'd0,
        CMD_PID     = 2'd1,
        CMD_VERSION = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] func;
        logic [7:0] sum;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

/* src/cfr_parser.sv */
// Front end: accepts received bytes, tracks the frame phase and the running
// sum, and pushes one command per dispatched frame. Depends on cfr_pkg.
`default_nettype none

module cfr_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata,
    input  wire cfr_pkg::queue_stat_t q_stat,
    output logic                      cmd_push,
    output cfr_pkg::cmd_t             cmd
);

    cfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] func_reg, func_next;
    logic [7:0] first_reg, first_next;
    logic       started_reg, started_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] limit_reg;
    logic       accept;
    logic       is_ack, is_pid, is_ver;

    // Only a checksum byte can produce a command, so only then does a full
    // command queue hold off the sender.
    assign full   = q_stat.full && (phase_reg == cfr_pkg::PH_CSUM);
    assign accept = push && !full;

    assign is_ack = (func_reg >= cfr_pkg::FUNC_ACK_LO) && (func_reg <= cfr_pkg::FUNC_ACK_HI);
    assign is_pid = (func_reg == cfr_pkg::FUNC_REQUEST) && (first_reg == cfr_pkg::SUB_PID);
    assign is_ver = (func_reg == cfr_pkg::FUNC_REQUEST) && (first_reg == cfr_pkg::SUB_VERSION);

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        func_next    = func_reg;
        first_next   = first_reg;
        started_next = started_reg;
        sum_next     = sum_reg;
        cmd_push     = 1'b0;
        cmd.func     = func_reg;
        cmd.sum      = sum_reg;
        if (is_ack)
        begin
            cmd.kind = cfr_pkg::CMD_ACK;
        end
        else if (is_pid)
        begin
            cmd.kind = cfr_pkg::CMD_PID;
        end
        else
        begin
            cmd.kind = cfr_pkg::CMD_VERSION;
        end

        if (accept)
        begin
            phase_next = cfr_pkg::PH_SYNC1;
            unique case (phase_reg)
                cfr_pkg::PH_SYNC1:
                begin
                    if (rx_byte == cfr_pkg::HDR1)
                    begin
                        phase_next = cfr_pkg::PH_SYNC2;
                        sum_next   = rx_byte;
                    end
                end
                cfr_pkg::PH_SYNC2:
                begin
                    if (rx_byte == cfr_pkg::HDR2)
                    begin
                        phase_next = cfr_pkg::PH_FUNC;
                        sum_next   = sum_reg + rx_byte;
                    end
                end
                cfr_pkg::PH_FUNC:
                begin
                    if (rx_byte < cfr_pkg::FUNC_LIMIT)
                    begin
                        phase_next = cfr_pkg::PH_LEN;
                        func_next  = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                    end
                end
                cfr_pkg::PH_LEN:
                begin
                    if (rx_byte < limit_reg)
                    begin
                        phase_next   = cfr_pkg::PH_PAYLOAD;
                        left_next    = rx_byte;
                        started_next = 1'b0;
                        sum_next     = sum_reg + rx_byte;
                    end
                end
                cfr_pkg::PH_PAYLOAD:
                begin
                    // A zero length lands here with nothing left and drops the frame.
                    if (left_reg != 8'd0)
                    begin
                        if (!started_reg)
                        begin
                            first_next   = rx_byte;
                            started_next = 1'b1;
                        end
                        sum_next  = sum_reg + rx_byte;
                        left_next = left_reg - 8'd1;
                        phase_next = (left_reg == 8'd1) ? cfr_pkg::PH_CSUM
                                                        : cfr_pkg::PH_PAYLOAD;
                    end
                end
                cfr_pkg::PH_CSUM:
                begin
                    cmd_push = (rx_byte == sum_reg) && (is_ack || is_pid || is_ver);
                end
                default:
                begin
                    phase_next = cfr_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= cfr_pkg::PH_SYNC1;
            left_reg    <= 8'd0;
            func_reg    <= 8'd0;
            first_reg   <= 8'd0;
            started_reg <= 1'b0;
            sum_reg     <= 8'd0;
            limit_reg   <= cfr_pkg::LIMIT_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            func_reg    <= func_next;
            first_reg   <= first_next;
            started_reg <= started_next;
            sum_reg     <= sum_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

/* src/cfr_cmd_queue.sv */
// Short command queue between the parser and the result emitter.
// Depends on cfr_pkg for the command and status types.
`default_nettype none

module cfr_cmd_queue #(
    parameter int DEPTH = cfr_pkg::CMD_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire cfr_pkg::cmd_t wr_data,
    input  wire logic          rd_en,
    output cfr_pkg::cmd_t      rd_data,
    output cfr_pkg::queue_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfr_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem[head_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                tail_reg <= (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
            end
            if (do_rd)
            begin
                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/cfr_emitter.sv */
// Back end: takes commands from the queue and presents their results one at a
// time, seven bytes for an acknowledgement. Depends on cfr_pkg.
`default_nettype none

module cfr_emitter (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfr_pkg::cmd_t        q_data,
    input  wire cfr_pkg::queue_stat_t q_stat,
    output logic                      q_pop,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      kind,
    output logic [7:0]                ack_byte,
    output logic                      pid_request,
    output logic                      version_request,
    output logic                      last
);

    cfr_pkg::cmd_t cmd_reg, cmd_next;
    logic [2:0]    step_reg, step_next;
    logic          busy_reg, busy_next;
    logic          done, taken;
    logic [7:0]    ack_value;
    logic [7:0]    ack_check;
    logic          is_ack_cmd;

    assign is_ack_cmd = (cmd_reg.kind == cfr_pkg::CMD_ACK);

    assign done  = !is_ack_cmd || (step_reg == cfr_pkg::ACK_LAST_STEP);
    assign taken = busy_reg && pop;
    assign q_pop = (!busy_reg || (taken && done)) && !q_stat.empty;

    assign ack_check = cfr_pkg::ACK_PREFIX_SUM + cmd_reg.func + cmd_reg.sum;

    always_comb
    begin
        unique case (step_reg)
            3'd0, 3'd1: ack_value = cfr_pkg::HDR1;
            3'd2:       ack_value = cfr_pkg::ACK_TAG;
            3'd3:       ack_value = cfr_pkg::ACK_LEN;
            3'd4:       ack_value = cmd_reg.func;
            3'd5:       ack_value = cmd_reg.sum;
            default:    ack_value = ack_check;
        endcase
    end

    assign empty           = !busy_reg;
    assign kind            = !is_ack_cmd;
    assign ack_byte        = is_ack_cmd ? ack_value : 8'd0;
    assign pid_request     = (cmd_reg.kind == cfr_pkg::CMD_PID);
    assign version_request = (cmd_reg.kind == cfr_pkg::CMD_VERSION);
    assign last            = done;

    always_comb
    begin
        cmd_next  = cmd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (q_pop)
        begin
            cmd_next  = q_data;
            step_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (taken && done)
        begin
            busy_next = 1'b0;
        end
        else if (taken)
        begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

/* src/checksummed_frame_receiver.sv */
// Top level of the checksummed frame receiver: parser, command queue and
// result emitter. Depends on cfr_pkg, cfr_parser, cfr_cmd_queue, cfr_emitter.
//
// Usage. Received bytes enter on rx_byte through a queue-style request port:
// a byte is taken at a clock edge where push is high and full is low. Bytes
// are taken one per cycle unless full; full rises only while the parser
// waits for a checksum byte and the command queue (CMD_DEPTH entries) is full.
// Results leave through a queue-style port: while empty is low the oldest
// result is on kind, ack_byte, pid_request, version_request and last, and it
// is taken at an edge where pop is high. A valid acknowledgement frame yields
// seven results, a valid request frame yields one; last marks the final one.
// The first result of a frame shows once its command has passed through
// the command queue into the emitter. The emitter gives one result per
// cycle while pop is high, so an acknowledgement holds the output side for
// its seven results; the command queue lets the parser keep taking bytes
// meanwhile. When the receiver stops popping, results wait on the port and
// later commands collect in the queue. The length limit is written through
// cfg_we and cfg_wdata while idle. Reset clears the parser to wait for a
// header, empties both sides and sets the length limit to 50.
`default_nettype none

module checksummed_frame_receiver #(
    parameter int CMD_DEPTH = cfr_pkg::CMD_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    output logic            empty,
    input  wire logic       pop,
    output logic            kind,
    output logic [7:0]      ack_byte,
    output logic            pid_request,
    output logic            version_request,
    output logic            last
);

    cfr_pkg::cmd_t        wr_cmd;
    cfr_pkg::cmd_t        rd_cmd;
    cfr_pkg::queue_stat_t q_stat;
    logic                 cmd_push;
    logic                 cmd_pop;

    // Front end: frame parsing and the length limit register.
    cfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .cmd_push  (cmd_push),
        .cmd       (wr_cmd)
    );

    // Decouples frame parsing from result delivery.
    cfr_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (wr_cmd),
        .rd_en   (cmd_pop),
        .rd_data (rd_cmd),
        .stat    (q_stat)
    );

    // Back end: expands each command into its results.
    cfr_emitter u_emitter (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_data          (rd_cmd),
        .q_stat          (q_stat),
        .q_pop           (cmd_pop),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .ack_byte        (ack_byte),
        .pid_request     (pid_request),
        .version_request (version_request),
        .last            (last)
    );

endmodule

`default_nettype wire

/* src/cfr_checker.sv */
// Port-level checker for the checksummed frame receiver, bound to the top
// level. Depends on checksummed_frame_receiver_macros.svh.
`default_nettype none
`include "checksummed_frame_receiver_macros.svh"

module cfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic       kind,
    input wire logic [7:0] ack_byte,
    input wire logic       pid_request,
    input wire logic       version_request,
    input wire logic       last
);

    logic [11:0] res;
    logic        req_ok;
    logic        any_req;
    logic        mid_ack;

    assign res     = {kind, ack_byte, pid_request, version_request, last};
    assign req_ok  = last && (ack_byte == 8'd0) && (pid_request ^ version_request);
    assign any_req = pid_request || version_request;
    assign mid_ack = !empty && !kind && !last;

    // A result that is not taken stays on the port unchanged.
    `CFR_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(res)), "stalled result changed")

    // A request event is a single result that names exactly one request.
    `CFR_ASSERT_IMPL(a_request, !empty && kind, req_ok, "malformed request event")

    // Acknowledgement bytes carry no request flag.
    `CFR_ASSERT_IMPL(a_ack_flags, !empty && !kind, !any_req, "request flag on ack byte")

    // Taking a byte of an acknowledgement that is not the last leaves the next one waiting.
    `CFR_ASSERT(a_burst, (mid_ack && pop) |=> (!empty && !kind), "ack burst broken")

endmodule

bind checksummed_frame_receiver cfr_checker u_cfr_checker (.*);

`default_nettype wire

/* tb/cfr_frame_checker.sv */
// Checker for the checksummed frame receiver: predicts the results of every
// accepted byte and compares them with the popped results, in order.
// Depends on cfr_pkg for the frame constants and the parser phase type.
module cfr_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] rx_byte,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       empty,
    input  logic       pop,
    input  logic       kind,
    input  logic [7:0] ack_byte,
    input  logic       pid_request,
    input  logic       version_request,
    input  logic       last,
    output int         errors,
    output int         outstanding,
    output int         checked,
    output int         ack_frames,
    output int         pid_events,
    output int         version_events
);
    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] ack_byte;
        logic       pid_request;
        logic       version_request;
        logic       last;
    } frame_result_t;

    frame_result_t expected_results[$];

    // Shadow of the parser and of the length limit register.
    logic [7:0] limit;
    phase_t     phase;
    logic [7:0] remaining;
    logic [7:0] func;
    logic [7:0] first_byte;
    logic       have_first;
    logic [7:0] sum;

    function automatic void parse_byte(input logic [7:0] b);
        logic [7:0] ack [7];
        logic [7:0] chk;
        int         i;
        if (phase == PH_SYNC1 && b == HDR1)
        begin
            phase = PH_SYNC2;
            sum   = b;
        end
        else if (phase == PH_SYNC2 && b == HDR2)
        begin
            phase = PH_FUNC;
            sum   = sum + b;
        end
        else if (phase == PH_FUNC && b < FUNC_LIMIT)
        begin
            phase = PH_LEN;
            func  = b;
            sum   = sum + b;
        end
        else if (phase == PH_LEN && b < limit)
        begin
            phase      = PH_PAYLOAD;
            remaining  = b;
            have_first = 1'b0;
            sum        = sum + b;
        end
        else if (phase == PH_PAYLOAD && remaining != 8'd0)
        begin
            if (!have_first)
            begin
                first_byte = b;
                have_first = 1'b1;
            end
            sum       = sum + b;
            remaining = remaining - 8'd1;
            if (remaining == 8'd0)
                phase = PH_CSUM;
        end
        else if (phase == PH_CSUM)
        begin
            phase = PH_SYNC1;
            // Only a good checksum with a known command dispatches a frame.
            if (b == sum)
            begin
                if (func >= FUNC_ACK_LO && func <= FUNC_ACK_HI)
                begin
                    ack = '{HDR1, HDR1, ACK_TAG, ACK_LEN, func, sum, 8'h00};
                    chk = 8'h00;
                    for (i = 0; i < 6; i++)
                        chk = chk + ack[i];
                    ack[6] = chk;
                    for (i = 0; i < 7; i++)
                        expected_results.push_back('{KIND_ACK, ack[i], 1'b0, 1'b0, i == 6});
                    ack_frames++;
                end
                else if (func == FUNC_REQUEST && first_byte == SUB_PID)
                begin
                    expected_results.push_back('{KIND_REQUEST, 8'h00, 1'b1, 1'b0, 1'b1});
                    pid_events++;
                end
                else if (func == FUNC_REQUEST && first_byte == SUB_VERSION)
                begin
                    expected_results.push_back('{KIND_REQUEST, 8'h00, 1'b0, 1'b1, 1'b1});
                    version_events++;
                end
            end
        end
        else
            phase = PH_SYNC1;
    endfunction

    function automatic void compare_field(input string what, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    function automatic void check_result();
        frame_result_t want;
        if (expected_results.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d byte %02h %0d%0d%0d",
                     $time, kind, ack_byte, pid_request, version_request, last);
        end
        else
        begin
            want = expected_results.pop_front();
            checked++;
            compare_field("kind", want.kind, kind);
            compare_field("ack_byte", want.ack_byte, ack_byte);
            compare_field("pid_request", want.pid_request, pid_request);
            compare_field("version_request", want.version_request, version_request);
            compare_field("last", want.last, last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit          = LIMIT_RESET;
            phase          = PH_SYNC1;
            remaining      = 8'd0;
            func           = 8'd0;
            first_byte     = 8'd0;
            have_first     = 1'b0;
            sum            = 8'd0;
            errors         = 0;
            checked        = 0;
            ack_frames     = 0;
            pid_events     = 0;
            version_events = 0;
            expected_results.delete();
            outstanding    = 0;
        end
        else
        begin
            if (cfg_we)
                limit = cfg_wdata;
            if (push && !full)
                parse_byte(rx_byte);
            if (pop && !empty)
                check_result();
            outstanding = expected_results.size();
        end
    end

endmodule

/* tb/checksummed_frame_receiver_test.sv */
// Top of the checksummed frame receiver testbench: clock, reset, byte and
// pop stimulus, length limit writes and the verdict.
// Depends on cfr_pkg, checksummed_frame_receiver and cfr_frame_checker.
module checksummed_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    // The hold-off stretch must outlast the time needed to fill the command
    // queue with acknowledgement frames, so that full is seen high.
    localparam int HOLD_CYCLES   = 150;
    // Cycles left after the last expected result, before a limit write and at
    // the end. The first result of a frame reaches the port through the command
    // queue and the emitter's command register, so this margin is plenty.
    localparam int SETTLE_CYCLES = 12;
    // Allows for the slowest correct run: a gap before every byte and a stall
    // before every result of a seven byte burst.
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic [7:0] byte_list_t[$];

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic       pop       = 1'b0;
    wire        full;
    wire        empty;
    wire        kind;
    wire [7:0]  ack_byte;
    wire        pid_request;
    wire        version_request;
    wire        last;

    int errors;
    int outstanding;
    int checked;
    int ack_frames;
    int pid_events;
    int version_events;

    // Handshake between the byte sender and the result receiver. These flags
    // are written with nonblocking assignments at the falling edge and read
    // at a later falling edge, so their order within a step never matters.
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    logic steady    = 1'b0;

    // Sender side bookkeeping, owned by the stimulus process alone.
    bit gaps_on = 1'b0;
    int bytes_sent = 0;
    int limits_used = 1;

    checksummed_frame_receiver dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .ack_byte        (ack_byte),
        .pid_request     (pid_request),
        .version_request (version_request),
        .last            (last)
    );

    cfr_frame_checker frame_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .ack_byte        (ack_byte),
        .pid_request     (pid_request),
        .version_request (version_request),
        .last            (last),
        .errors          (errors),
        .outstanding     (outstanding),
        .checked         (checked),
        .ack_frames      (ack_frames),
        .pid_events      (pid_events),
        .version_events  (version_events)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Guard against a hung handshake or results that never arrive.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("checksummed_frame_receiver_test: done, errors");
        $finish;
    end

    // Every sender task starts and ends at a falling edge. A byte request
    // leaves push high on return, so back-to-back bytes keep push high
    // without a dip; anything that stops sending drops push first.
    task automatic sender_idle(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 99) < 12)
            sender_idle($urandom_range(1, 18));
        push    <= 1'b1;
        rx_byte <= b;
        // The request is taken at the first rising edge where full is low.
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_bytes(input byte_list_t frame);
        foreach (frame[i])
            push_byte(frame[i]);
    endtask

    // Header, function, length, payload and a correct checksum. The first
    // payload byte is chosen by the caller since it selects the request type.
    function automatic byte_list_t build_frame(input logic [7:0] func, input logic [7:0] len,
                                               input logic [7:0] first);
        byte_list_t frame;
        logic [7:0] s;
        frame = '{HDR1, HDR2, func, len};
        for (int i = 0; i < len; i++)
            frame.push_back(i == 0 ? first : 8'($urandom_range(0, 255)));
        s = 8'h00;
        foreach (frame[i])
            s = s + frame[i];
        frame.push_back(s);
        return frame;
    endfunction

    // Mostly well-formed frames with random content, so the parser gets deep
    // into payload and checksum; the rest are bad checksums, cut-off frames,
    // stray bytes ahead of a header, oversized functions and long lengths.
    task automatic random_frame();
        byte_list_t frame;
        logic [7:0] func;
        logic [7:0] len;
        logic [7:0] first;
        int         pick;
        int         keep;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            func = 8'($urandom_range(FUNC_ACK_LO, FUNC_ACK_HI));
        else if (pick < 65)
            func = FUNC_REQUEST;
        else if (pick < 88)
            func = 8'($urandom_range(0, FUNC_LIMIT - 1));
        else
            func = 8'($urandom_range(FUNC_LIMIT, 255));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            first = SUB_PID;
        else if (pick < 75)
            first = SUB_VERSION;
        else
            first = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 4)
            len = 8'($urandom_range(0, 255));
        else
            len = 8'($urandom_range(0, 7));
        frame = build_frame(func, len, first);
        if ($urandom_range(0, 99) < 12)
            frame[frame.size() - 1] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < 6)
        begin
            keep = $urandom_range(1, frame.size() - 1);
            while (frame.size() > keep)
                void'(frame.pop_back());
        end
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 3))
                frame.push_front($urandom_range(0, 1) ? HDR1 : 8'($urandom_range(0, 255)));
        end
        send_bytes(frame);
    endtask

    task automatic random_until(input int target);
        while (bytes_sent < target)
            random_frame();
    endtask

    // Waits until every predicted result has been popped, then lets the
    // block settle, since a byte that causes no result leaves nothing to wait on.
    task automatic settle();
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The limit register is only written while the block is idle.
    task automatic write_limit(input logic [7:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limits_used++;
    endtask

    // Result side: random stall bursts, one long hold-off on request from the
    // sender, and a steady pop for the closing part of the run.
    initial
    begin
        int stall;
        int held;
        stall = 0;
        held  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                pop <= 1'b0;
                held++;
                if (held == HOLD_CYCLES)
                    hold_done <= 1'b1;
            end
            else if (steady)
                pop <= 1'b1;
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 99) < 8)
            begin
                pop   <= 1'b0;
                stall = $urandom_range(1, 18) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset limit: the lowest acknowledged function
        // with an all-ones payload, both request kinds, a function byte that
        // is just too large, and a zero length frame that must be dropped.
        send_bytes(build_frame(FUNC_ACK_LO, 8'd1, 8'hFF));
        send_bytes(build_frame(FUNC_REQUEST, 8'd1, SUB_PID));
        send_bytes(build_frame(FUNC_REQUEST, 8'd1, SUB_VERSION));
        send_bytes('{HDR1, HDR2, FUNC_LIMIT});
        send_bytes(build_frame(FUNC_ACK_HI, 8'd0, 8'h00));

        gaps_on = 1'b1;
        random_until(80);

        // Long hold-off on the result side while acknowledgement frames keep
        // coming at full rate, so the command queue fills and full stalls
        // the byte requests.
        gaps_on = 1'b0;
        hold_req <= 1'b1;
        while (!hold_done)
            send_bytes(build_frame(8'($urandom_range(FUNC_ACK_LO, FUNC_ACK_HI)), 8'd1,
                                   8'($urandom_range(0, 255))));
        gaps_on = 1'b1;
        random_until(150);

        // Largest limit, then one that passes only a zero length, then
        // a limit that rejects every length, then a small one.
        write_limit(8'd255);
        random_until(200);
        write_limit(8'd1);
        random_until(225);
        write_limit(8'd0);
        random_until(240);
        write_limit(8'd7);
        random_until(275);

        // Closing part back at the reset limit with no idling on either side.
        write_limit(LIMIT_RESET);
        gaps_on = 1'b0;
        steady <= 1'b1;
        random_until(335);

        settle();
        $display("Sent %0d bytes under %0d length limits; %0d results checked.",
                 bytes_sent, limits_used, checked);
        $display("Predicted %0d acknowledgement frames, %0d PID and %0d version requests.",
                 ack_frames, pid_events, version_events);
        if (errors == 0)
            $display("checksummed_frame_receiver_test: done, clean");
        else
            $display("checksummed_frame_receiver_test: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/cfr_pkg.sv
src/cfr_parser.sv
src/cfr_cmd_queue.sv
src/cfr_emitter.sv
src/checksummed_frame_receiver.sv
src/cfr_checker.sv
tb/cfr_frame_checker.sv
tb/checksummed_frame_receiver_test.sv
